/* hw/rtl/i2cm_pkg.sv */
`default_nettype none

package i2cm_pkg;

   // bits shifted per byte transfer
   localparam int unsigned BITS_PER_BYTE = 8;

   localparam int unsigned PHASE_W = 3;
   localparam int unsigned BIT_W   = 4;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned ACT_W   = 3;

   localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd5;

   // action codes carried on the input channel
   localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_START = 3'd1;
   localparam logic [ACT_W-1:0] ACT_WRITE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_STOP  = 3'd4;

   // bus phase numbers
   localparam logic [PHASE_W-1:0] PH_0 = 3'd0;
   localparam logic [PHASE_W-1:0] PH_1 = 3'd1;
   localparam logic [PHASE_W-1:0] PH_2 = 3'd2;
   localparam logic [PHASE_W-1:0] PH_3 = 3'd3;
   localparam logic [PHASE_W-1:0] PH_4 = 3'd4;
   localparam logic [PHASE_W-1:0] PH_5 = 3'd5;
   localparam logic [PHASE_W-1:0] PH_6 = 3'd6;

   // running command
   typedef enum logic [4:0] {
      OP_IDLE  = 5'b00001,
      OP_START = 5'b00010,
      OP_WRITE = 5'b00100,
      OP_READ  = 5'b01000,
      OP_STOP  = 5'b10000
   } op_type;

   // one accepted transaction
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [BYTE_W-1:0] data_byte;
      logic              send_nack;
      logic              sda_in;
   } item_type;

   // result fields
   typedef struct packed {
      logic              scl_level;
      logic              sda_drive;
      logic              busy_res;
      logic              done_res;
      logic              ack_seen;
      logic [BYTE_W-1:0] read_data;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/i2cm_core.sv */
`default_nettype none

module i2cm_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire i2cm_pkg::item_type            item,
   input  wire logic [i2cm_pkg::TICK_W-1:0]   phase_ticks,
   output i2cm_pkg::result_type               result
);

   // levels and shift register after a phase begins
   typedef struct packed {
      logic                          scl;
      logic                          sda;
      logic [i2cm_pkg::BYTE_W-1:0]   shift;
   } lvl_type;

   function automatic lvl_type set_levels(
      input i2cm_pkg::op_type                 op,
      input logic [i2cm_pkg::PHASE_W-1:0]     ph,
      input logic [i2cm_pkg::BYTE_W-1:0]      sh,
      input logic                             nk,
      input logic                             scl,
      input logic                             sda
   );
      lvl_type r;
      r.scl   = scl;
      r.sda   = sda;
      r.shift = sh;
      case (op)
         i2cm_pkg::OP_START: begin
            if (ph == i2cm_pkg::PH_0) begin
               r.sda = 1'b1;
               r.scl = 1'b1;
            end else begin
               r.sda = 1'b0;
            end
         end
         i2cm_pkg::OP_STOP: begin
            if (ph == i2cm_pkg::PH_0) begin
               r.scl = 1'b0;
               r.sda = 1'b0;
            end else begin
               r.scl = 1'b1;
               r.sda = 1'b1;
            end
         end
         i2cm_pkg::OP_WRITE: begin
            case (ph)
               i2cm_pkg::PH_0: r.scl = 1'b0;
               i2cm_pkg::PH_1: begin
                  r.sda   = sh[i2cm_pkg::BYTE_W-1];
                  r.shift = {sh[i2cm_pkg::BYTE_W-2:0], 1'b0};
               end
               i2cm_pkg::PH_2: r.scl = 1'b1;
               i2cm_pkg::PH_3: r.scl = 1'b0;
               i2cm_pkg::PH_4: r.sda = 1'b1;
               i2cm_pkg::PH_5: r.scl = 1'b1;
               default:        r.scl = 1'b0;
            endcase
         end
         i2cm_pkg::OP_READ: begin
            case (ph)
               i2cm_pkg::PH_0: r.scl = 1'b0;
               i2cm_pkg::PH_1: begin
                  r.sda = 1'b1;
                  r.scl = 1'b1;
               end
               i2cm_pkg::PH_2: r.scl = 1'b0;
               i2cm_pkg::PH_3: r.scl = 1'b0;
               i2cm_pkg::PH_4: r.sda = nk;
               i2cm_pkg::PH_5: r.scl = 1'b1;
               default:        r.scl = 1'b0;
            endcase
         end
         default: r.scl = scl;
      endcase
      return r;
   endfunction

   i2cm_pkg::op_type                   op_ff, op_in;
   logic [i2cm_pkg::PHASE_W-1:0]       phase_ff, phase_in;
   logic [i2cm_pkg::BIT_W-1:0]         bit_ff, bit_in;
   logic [i2cm_pkg::TICK_W-1:0]        tick_ff, tick_in;
   logic [i2cm_pkg::BYTE_W-1:0]        shift_ff, shift_in;
   logic                               nack_ff, nack_in;
   logic                               scl_ff, scl_in;
   logic                               sda_ff, sda_in;
   logic                               ack_ff, ack_in;
   logic                               done_ff, done_in;

   logic [i2cm_pkg::TICK_W-1:0]        limit;
   logic [i2cm_pkg::TICK_W-1:0]        tick_inc;
   logic [i2cm_pkg::BIT_W-1:0]         bit_inc;
   logic                               finished;
   lvl_type                            lvl;

   assign limit    = (phase_ticks == '0) ? i2cm_pkg::TICK_W'(1) : phase_ticks;
   assign tick_inc = tick_ff + i2cm_pkg::TICK_W'(1);
   assign bit_inc  = bit_ff + i2cm_pkg::BIT_W'(1);

   // sequencer next state for one transaction
   always_comb begin
      op_in    = op_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      nack_in  = nack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      done_in  = 1'b0;
      finished = 1'b0;
      lvl      = '0;

      if (op_ff == i2cm_pkg::OP_IDLE) begin
         // command launch, first phase levels
         if (item.action == i2cm_pkg::ACT_START || item.action == i2cm_pkg::ACT_WRITE ||
             item.action == i2cm_pkg::ACT_READ || item.action == i2cm_pkg::ACT_STOP) begin
            case (item.action)
               i2cm_pkg::ACT_START: op_in = i2cm_pkg::OP_START;
               i2cm_pkg::ACT_WRITE: op_in = i2cm_pkg::OP_WRITE;
               i2cm_pkg::ACT_READ:  op_in = i2cm_pkg::OP_READ;
               default:             op_in = i2cm_pkg::OP_STOP;
            endcase
            phase_in = i2cm_pkg::PH_0;
            bit_in   = '0;
            tick_in  = '0;
            if (item.action == i2cm_pkg::ACT_WRITE) begin
               shift_in = item.data_byte;
            end
            if (item.action == i2cm_pkg::ACT_READ) begin
               shift_in = '0;
               nack_in  = item.send_nack;
            end
            lvl    = set_levels(op_in, phase_in, shift_in, nack_in, scl_in, sda_in);
            scl_in = lvl.scl;
            sda_in = lvl.sda;
            shift_in = lvl.shift;
         end
      end else if (tick_inc < limit) begin
         tick_in = tick_inc;
      end else begin
         // phase end: sample and move on
         tick_in = '0;
         case (op_ff)
            i2cm_pkg::OP_START: begin
               if (phase_ff == i2cm_pkg::PH_0) begin
                  phase_in = i2cm_pkg::PH_1;
               end else begin
                  scl_in   = 1'b0;
                  finished = 1'b1;
               end
            end
            i2cm_pkg::OP_STOP: begin
               if (phase_ff == i2cm_pkg::PH_0) begin
                  phase_in = i2cm_pkg::PH_1;
               end else begin
                  finished = 1'b1;
               end
            end
            i2cm_pkg::OP_WRITE: begin
               if (phase_ff < i2cm_pkg::PH_2) begin
                  phase_in = phase_ff + i2cm_pkg::PHASE_W'(1);
               end else if (phase_ff == i2cm_pkg::PH_2) begin
                  bit_in   = bit_inc;
                  phase_in = (bit_inc < i2cm_pkg::BIT_W'(i2cm_pkg::BITS_PER_BYTE)) ?
                             i2cm_pkg::PH_0 : i2cm_pkg::PH_3;
               end else if (phase_ff < i2cm_pkg::PH_6) begin
                  if (phase_ff == i2cm_pkg::PH_5) begin
                     ack_in = item.sda_in;
                  end
                  phase_in = phase_ff + i2cm_pkg::PHASE_W'(1);
               end else begin
                  finished = 1'b1;
               end
            end
            i2cm_pkg::OP_READ: begin
               if (phase_ff == i2cm_pkg::PH_0) begin
                  phase_in = i2cm_pkg::PH_1;
               end else if (phase_ff == i2cm_pkg::PH_1) begin
                  shift_in = {shift_ff[i2cm_pkg::BYTE_W-2:0], item.sda_in};
                  phase_in = i2cm_pkg::PH_2;
               end else if (phase_ff == i2cm_pkg::PH_2) begin
                  bit_in   = bit_inc;
                  phase_in = (bit_inc < i2cm_pkg::BIT_W'(i2cm_pkg::BITS_PER_BYTE)) ?
                             i2cm_pkg::PH_1 : i2cm_pkg::PH_3;
               end else if (phase_ff < i2cm_pkg::PH_6) begin
                  phase_in = phase_ff + i2cm_pkg::PHASE_W'(1);
               end else begin
                  sda_in   = 1'b1;
                  finished = 1'b1;
               end
            end
            default: finished = 1'b1;
         endcase

         if (finished) begin
            op_in    = i2cm_pkg::OP_IDLE;
            phase_in = i2cm_pkg::PH_0;
            bit_in   = '0;
            done_in  = 1'b1;
         end else begin
            lvl      = set_levels(op_ff, phase_in, shift_in, nack_ff, scl_in, sda_in);
            scl_in   = lvl.scl;
            sda_in   = lvl.sda;
            shift_in = lvl.shift;
         end
      end
   end

   // sequencer state, advances once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= i2cm_pkg::OP_IDLE;
         phase_ff <= i2cm_pkg::PH_0;
         bit_ff   <= '0;
         tick_ff  <= '0;
         shift_ff <= '0;
         nack_ff  <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else if (step) begin
         op_ff    <= op_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         nack_ff  <= nack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         done_ff  <= done_in;
      end
   end

   // result fields come straight from the updated state
   assign result.scl_level = scl_ff;
   assign result.sda_drive = sda_ff;
   assign result.busy_res  = (op_ff != i2cm_pkg::OP_IDLE);
   assign result.done_res  = done_ff;
   assign result.ack_seen  = ack_ff;
   assign result.read_data = shift_ff;

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_byte_engine_unit.sv */
// channel   ports                                   direction
// req       req_valid/req_ready, action, data_byte,  in
//           send_nack, sda_in
// rsp       rsp_valid/rsp_ready, scl_level,          out
//           sda_drive, busy_res, done_res, ack_seen, read_data
// csr       csr_wr_en, csr_wr_data (phase_ticks)     in
//
// one transaction per cycle sustained while rsp is not stalled; an accepted transaction passes
// the input register, then the sequencer state, which doubles as the result register
// synchronous reset puts the bus lines released and the sequencer idle
// a stalled rsp holds the sequencer; the input register still takes one
// transaction, then req_ready drops until rsp drains

`default_nettype none

module i2c_master_byte_engine_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [i2cm_pkg::ACT_W-1:0]        req_action,
   input  wire logic [i2cm_pkg::BYTE_W-1:0]       req_data_byte,
   input  wire logic                              req_send_nack,
   input  wire logic                              req_sda_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_scl_level,
   output logic                                   rsp_sda_drive,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic                                   rsp_ack_seen,
   output logic [i2cm_pkg::BYTE_W-1:0]            rsp_read_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [i2cm_pkg::TICK_W-1:0]       csr_wr_data
);

   logic                              in_valid_ff, in_valid_in;
   i2cm_pkg::item_type                in_item_ff;
   logic                              out_valid_ff, out_valid_in;
   logic [i2cm_pkg::TICK_W-1:0]       phase_ticks_ff;
   logic                              out_free;
   logic                              step;
   i2cm_pkg::result_type              result;

   // handshake between the two stages
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_ready);

   // valid flags of the input register and the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.action    <= req_action;
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.send_nack <= req_send_nack;
         in_item_ff.sda_in    <= req_sda_in;
      end
   end

   // phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RST;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   i2cm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (in_item_ff),
      .phase_ticks (phase_ticks_ff),
      .result      (result)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = result.scl_level;
   assign rsp_sda_drive = result.sda_drive;
   assign rsp_busy_res  = result.busy_res;
   assign rsp_done_res  = result.done_res;
   assign rsp_ack_seen  = result.ack_seen;
   assign rsp_read_data = result.read_data;

endmodule

`default_nettype wire

/* tb/sv/i2c_master_byte_engine_unit_tb.sv */
`timescale 1ns / 100ps

module i2c_master_byte_engine_unit_tb;
   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT  = 100_000;
   localparam int RANDOM_ITEMS = 650;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE       = 4;

   // how the sampled sda level is chosen while a command runs
   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [ACT_W-1:0]    req_action    = ACT_TICK;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_send_nack = 1'b0;
   logic                req_sda_in    = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic                rsp_scl_level;
   logic                rsp_sda_drive;
   logic                rsp_busy_res;
   logic                rsp_done_res;
   logic                rsp_ack_seen;
   logic [BYTE_W-1:0]   rsp_read_data;
   logic                csr_wr_en     = 1'b0;
   logic [TICK_W-1:0]   csr_wr_data   = PHASE_TICKS_RST;

   // bus sequencer prediction state
   op_type              seq_op    = OP_IDLE;
   logic [PHASE_W-1:0]  seq_phase = PH_0;
   logic [BIT_W-1:0]    seq_bit   = '0;
   logic [TICK_W-1:0]   seq_ticks = '0;
   logic [BYTE_W-1:0]   seq_shift = '0;
   logic                seq_nack  = 1'b0;
   logic                seq_scl   = 1'b1;
   logic                seq_sda   = 1'b1;
   logic                seq_ack   = 1'b0;
   logic [TICK_W-1:0]   phase_ticks_cfg = PHASE_TICKS_RST;

   result_type          expected_lines[$];
   result_type          want_res;
   int                  error_count  = 0;
   int                  items_sent   = 0;
   int                  cycle_count  = 0;
   bit                  idling_on    = 1'b1;
   int                  holds_asked  = 0;
   int                  holds_served = 0;
   int                  hold_left    = 0;
   int                  stall_left   = 0;

   i2c_master_byte_engine_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .req_send_nack (req_send_nack),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_scl_level (rsp_scl_level),
      .rsp_sda_drive (rsp_sda_drive),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_ack_seen  (rsp_ack_seen),
      .rsp_read_data (rsp_read_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // line levels at the start of the current phase
   function automatic void set_phase_levels();
      case (seq_op)
         OP_START: begin
            if (seq_phase == PH_0) begin
               seq_sda = 1'b1;
               seq_scl = 1'b1;
            end else begin
               seq_sda = 1'b0;
            end
         end
         OP_STOP: begin
            seq_scl = (seq_phase != PH_0);
            seq_sda = (seq_phase != PH_0);
         end
         OP_WRITE: begin
            case (seq_phase)
               PH_0: seq_scl = 1'b0;
               PH_1: begin
                  seq_sda   = seq_shift[7];
                  seq_shift = {seq_shift[6:0], 1'b0};
               end
               PH_2: seq_scl = 1'b1;
               PH_3: seq_scl = 1'b0;
               PH_4: seq_sda = 1'b1;
               PH_5: seq_scl = 1'b1;
               default: seq_scl = 1'b0;
            endcase
         end
         OP_READ: begin
            case (seq_phase)
               PH_0: seq_scl = 1'b0;
               PH_1: begin
                  seq_sda = 1'b1;
                  seq_scl = 1'b1;
               end
               PH_2: seq_scl = 1'b0;
               PH_3: seq_scl = 1'b0;
               PH_4: seq_sda = seq_nack;
               PH_5: seq_scl = 1'b1;
               default: seq_scl = 1'b0;
            endcase
         end
         default: ;
      endcase
   endfunction

   // phase has run its ticks: take the sample and move on, 1 when the command ends
   function automatic logic close_phase(logic sda);
      logic fin;
      fin = 1'b0;
      case (seq_op)
         OP_START: begin
            if (seq_phase == PH_0) begin
               seq_phase = PH_1;
            end else begin
               seq_scl = 1'b0;
               fin = 1'b1;
            end
         end
         OP_STOP: begin
            if (seq_phase == PH_0) seq_phase = PH_1;
            else fin = 1'b1;
         end
         OP_WRITE: begin
            if (seq_phase < PH_2) begin
               seq_phase++;
            end else if (seq_phase == PH_2) begin
               seq_bit++;
               seq_phase = (seq_bit < BITS_PER_BYTE) ? PH_0 : PH_3;
            end else if (seq_phase < PH_6) begin
               if (seq_phase == PH_5) seq_ack = sda;
               seq_phase++;
            end else begin
               fin = 1'b1;
            end
         end
         OP_READ: begin
            if (seq_phase == PH_0) begin
               seq_phase = PH_1;
            end else if (seq_phase == PH_1) begin
               seq_shift = {seq_shift[6:0], sda};
               seq_phase = PH_2;
            end else if (seq_phase == PH_2) begin
               seq_bit++;
               seq_phase = (seq_bit < BITS_PER_BYTE) ? PH_1 : PH_3;
            end else if (seq_phase < PH_6) begin
               seq_phase++;
            end else begin
               seq_sda = 1'b1;
               fin = 1'b1;
            end
         end
         default: fin = 1'b1;
      endcase
      if (fin) begin
         seq_op    = OP_IDLE;
         seq_phase = PH_0;
         seq_bit   = '0;
      end else begin
         set_phase_levels();
      end
      return fin;
   endfunction

   // advance the sequencer by one transaction and give the line state it reports
   function automatic result_type predict_bus_step(item_type it);
      result_type        r;
      logic [TICK_W-1:0] lim;
      logic              fin;
      fin = 1'b0;
      if (seq_op == OP_IDLE) begin
         case (it.action)
            ACT_START: seq_op = OP_START;
            ACT_WRITE: seq_op = OP_WRITE;
            ACT_READ:  seq_op = OP_READ;
            ACT_STOP:  seq_op = OP_STOP;
            default: ;
         endcase
         if (seq_op != OP_IDLE) begin
            seq_phase = PH_0;
            seq_bit   = '0;
            seq_ticks = '0;
            if (seq_op == OP_WRITE) seq_shift = it.data_byte;
            if (seq_op == OP_READ) begin
               seq_shift = '0;
               seq_nack  = it.send_nack;
            end
            set_phase_levels();
         end
      end else begin
         lim = (phase_ticks_cfg == '0) ? TICK_W'(1) : phase_ticks_cfg;
         seq_ticks++;
         if (seq_ticks >= lim) begin
            seq_ticks = '0;
            fin = close_phase(it.sda_in);
         end
      end
      r.scl_level = seq_scl;
      r.sda_drive = seq_sda;
      r.busy_res  = (seq_op != OP_IDLE);
      r.done_res  = fin;
      r.ack_seen  = seq_ack;
      r.read_data = seq_shift;
      return r;
   endfunction

   function automatic item_type make_item(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data,
                                          logic nack, logic sda);
      item_type t;
      t.action    = act;
      t.data_byte = data;
      t.send_nack = nack;
      t.sda_in    = sda;
      return t;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // one transaction on the request channel, predicted once accepted
   task automatic send_item(item_type t);
      int gap;
      gap = idling_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= t.action;
      req_data_byte <= t.data_byte;
      req_send_nack <= t.send_nack;
      req_sda_in    <= t.sda_in;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_lines.push_back(predict_bus_step(t));
      items_sent++;
   endtask

   // stop offering and wait until every expected result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_phase_ticks(logic [TICK_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      phase_ticks_cfg = value;
   endtask

   // tick until the running command ends; noisy ticks sometimes carry other actions
   task automatic finish_command(int sda_mode, bit noisy);
      item_type t;
      while (seq_op != OP_IDLE) begin
         t = make_item(ACT_TICK, BYTE_W'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'b0);
         if (noisy && $urandom_range(0, 9) == 0) t.action = ACT_W'($urandom_range(0, 7));
         t.sda_in = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : sda_mode[0];
         send_item(t);
      end
   endtask

   task automatic run_command(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] data, logic nack,
                              int sda_mode);
      send_item(make_item(act, data, nack, 1'($urandom_range(0, 1))));
      finish_command(sda_mode, sda_mode == SDA_RANDOM);
   endtask

   // ticks and unknown actions while idle change nothing
   task automatic test_idle_items();
      send_item(make_item(ACT_TICK, 8'hff, 1'b1, 1'b0));
      send_item(make_item(ACT_TICK, 8'h00, 1'b0, 1'b1));
      send_item(make_item(3'd5, 8'hff, 1'b1, 1'b1));
      send_item(make_item(3'd6, 8'h00, 1'b0, 1'b0));
      send_item(make_item(3'd7, 8'hff, 1'b1, 1'b1));
   endtask

   // start and stop conditions at the reset phase length
   task automatic test_start_stop();
      run_command(ACT_START, 8'h00, 1'b0, SDA_HIGH);
      run_command(ACT_STOP, 8'hff, 1'b1, SDA_LOW);
   endtask

   // writes with slave ack and nack
   task automatic test_write_byte();
      set_phase_ticks(16'd1);
      run_command(ACT_WRITE, 8'hff, 1'b0, SDA_HIGH);
      run_command(ACT_WRITE, 8'h00, 1'b1, SDA_LOW);
      run_command(ACT_WRITE, 8'ha5, 1'b0, SDA_RANDOM);
   endtask

   // reads answered with ack and nack; a write afterwards clears read_data
   task automatic test_read_byte();
      run_command(ACT_READ, 8'h00, 1'b0, SDA_HIGH);
      run_command(ACT_READ, 8'hff, 1'b1, SDA_LOW);
      run_command(ACT_READ, 8'h5a, 1'b1, SDA_RANDOM);
      run_command(ACT_WRITE, 8'h3c, 1'b0, SDA_LOW);
   endtask

   // every command and unknown action offered while a write runs is only a tick
   task automatic test_busy_commands();
      send_item(make_item(ACT_WRITE, 8'h5a, 1'b0, 1'b0));
      for (int a = ACT_START; a <= 7; a++)
         send_item(make_item(ACT_W'(a), 8'hff, 1'b1, 1'($urandom_range(0, 1))));
      finish_command(SDA_RANDOM, 1'b0);
   endtask

   // zero phase length acts as one; longest phase length, then shortened mid-phase
   task automatic test_phase_ticks_limits();
      set_phase_ticks(16'd0);
      run_command(ACT_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(ACT_WRITE, 8'h81, 1'b0, SDA_RANDOM);
      run_command(ACT_READ, 8'h00, 1'b0, SDA_RANDOM);
      set_phase_ticks(16'hffff);
      idling_on = 1'b0;
      send_item(make_item(ACT_START, 8'h00, 1'b0, 1'b0));
      repeat (40) send_item(make_item(ACT_TICK, 8'h00, 1'b0, 1'b1));
      set_phase_ticks(16'd2);
      finish_command(SDA_RANDOM, 1'b0);
      idling_on = 1'b1;
   endtask

   // long hold on the result side while requests keep coming
   task automatic test_stall_backpressure();
      idling_on = 1'b0;
      holds_asked++;
      send_item(make_item(ACT_START, 8'h00, 1'b0, 1'b0));
      repeat (40) send_item(make_item(ACT_TICK, BYTE_W'($urandom_range(0, 255)), 1'b0,
                                      1'($urandom_range(0, 1))));
      finish_command(SDA_RANDOM, 1'b1);
      idling_on = 1'b1;
   endtask

   // start, address write, mixed writes and reads, mostly a stop at the end
   task automatic run_bus_transfer();
      int n_bytes;
      n_bytes = $urandom_range(1, 4);
      run_command(ACT_START, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  SDA_RANDOM);
      run_command(ACT_WRITE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  SDA_RANDOM);
      for (int i = 1; i < n_bytes; i++) begin
         if ($urandom_range(0, 1))
            run_command(ACT_WRITE, BYTE_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), SDA_RANDOM);
         else
            run_command(ACT_READ, BYTE_W'($urandom_range(0, 255)),
                        (i == n_bytes - 1) ? ($urandom_range(0, 3) != 0)
                                           : 1'($urandom_range(0, 1)), SDA_RANDOM);
      end
      if ($urandom_range(0, 9) != 0)
         run_command(ACT_STOP, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     SDA_RANDOM);
   endtask

   // random actions and fields, whatever comes of them
   task automatic run_bus_noise();
      repeat ($urandom_range(1, 4)) begin
         send_item(make_item(ACT_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         finish_command(SDA_RANDOM, 1'b1);
      end
   endtask

   task automatic test_random_traffic();
      int goal;
      int r;
      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         r = $urandom_range(0, 9);
         set_phase_ticks((r < 5) ? 16'd1 : (r < 8) ? 16'd2 : 16'($urandom_range(0, 4)));
         idling_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 9) < 8) run_bus_transfer();
            else run_bus_noise();
         end
      end
      idling_on = 1'b1;
   endtask

   // result side: random stalls plus the requested long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idling_on) stall_left = pick_gap();
      end
   end

   // compare each result transaction with the oldest expected line state
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lines.size() == 0) begin
            $error("result transaction with nothing expected");
            error_count++;
         end else begin
            want_res = expected_lines.pop_front();
            check_field("scl_level", 8'(want_res.scl_level), 8'(rsp_scl_level));
            check_field("sda_drive", 8'(want_res.sda_drive), 8'(rsp_sda_drive));
            check_field("busy_res", 8'(want_res.busy_res), 8'(rsp_busy_res));
            check_field("done_res", 8'(want_res.done_res), 8'(rsp_done_res));
            check_field("ack_seen", 8'(want_res.ack_seen), 8'(rsp_ack_seen));
            check_field("read_data", want_res.read_data, rsp_read_data);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_items();
      test_start_stop();
      test_write_byte();
      test_read_byte();
      test_busy_commands();
      test_phase_ticks_limits();
      test_stall_backpressure();
      test_random_traffic();
      drain_results();
      if (expected_lines.size() != 0) begin
         $error("%0d expected results never arrived", expected_lines.size());
         error_count++;
      end
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_core.sv
hw/rtl/i2c_master_byte_engine_unit.sv
tb/sv/i2c_master_byte_engine_unit_tb.sv
